FILE: rtl/sesr_pkg.sv
// shared types and constants for the speaker event sample renderer
package sesr_pkg;

    localparam int TIME_W     = 64;
    localparam int AMP_W      = 15;
    localparam int STEP_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_RENDER = 2'd2,
        FUNC_UNUSED = 2'd3
    } func_t;

    typedef enum logic [0:0] {
        REG_AMPLITUDE   = 1'b0,
        REG_SAMPLE_STEP = 1'b1
    } reg_idx_t;

    // command passed from front to back
    typedef struct packed {
        logic              is_render;
        logic              level;
        logic [TIME_W-1:0] stamp;
    } cmd_t;

    // one recorded speaker toggle
    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] stamp;
    } spk_evt_t;

endpackage

FILE: rtl/sesr_front.sv
// front end: accepts items, keeps the time counter and writer level, issues commands
module sesr_front
    import sesr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // [7:0] port_value
    input  logic [IN_USER_W-1:0] s_tuser,   // [1:0] func
    input  logic                 cmdq_full,
    output logic                 cmd_push,
    output cmd_t                 cmd_out
);

    logic [TIME_W-1:0] time_counter_reg;
    logic [TIME_W-1:0] time_counter_next;
    logic              writer_level_reg;
    logic              writer_level_next;
    logic              accept;
    logic              new_level;
    func_t             func;

    assign s_tready  = !cmdq_full;
    assign accept    = s_tvalid && s_tready;
    assign func      = func_t'(s_tuser);
    assign new_level = |s_tdata[7:6];

    always_comb
    begin
        time_counter_next = time_counter_reg;
        writer_level_next = writer_level_reg;
        cmd_push          = 1'b0;
        cmd_out.is_render = 1'b0;
        cmd_out.level     = new_level;
        cmd_out.stamp     = time_counter_reg;
        if (accept)
        begin
            case (func)
                FUNC_TICK:
                begin
                    time_counter_next = time_counter_reg + TIME_W'(1);
                end
                FUNC_WRITE:
                begin
                    if (new_level != writer_level_reg)
                    begin
                        writer_level_next = new_level;
                        cmd_push          = 1'b1;
                    end
                end
                FUNC_RENDER:
                begin
                    cmd_out.is_render = 1'b1;
                    cmd_push          = 1'b1;
                end
                default:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_counter_reg <= '0;
            writer_level_reg <= 1'b0;
        end
        else
        begin
            time_counter_reg <= time_counter_next;
            writer_level_reg <= writer_level_next;
        end
    end

endmodule

FILE: rtl/sesr_cmdq.sv
// short command queue between front and back
module sesr_cmdq
    import sesr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd,
    input  logic pop
);

    cmd_t                  slots [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] head_reg;
    logic [CMDQ_PTR_W-1:0] head_next;
    logic [CMDQ_PTR_W-1:0] tail_reg;
    logic [CMDQ_PTR_W-1:0] tail_next;
    logic [CMDQ_CNT_W-1:0] count_reg;
    logic [CMDQ_CNT_W-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots[head_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                  : tail_reg + CMDQ_PTR_W'(1);
        end
        if (do_pop)
        begin
            head_next = (head_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                  : head_reg + CMDQ_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CMDQ_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[tail_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CMDQ_CNT_W'(CMDQ_DEPTH))
        else $error("command queue count out of range");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CMDQ_CNT_W'(1))
        else $error("command queue count missed a push");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> head_reg == tail_reg)
        else $error("command queue pointers disagree when empty");

endmodule

FILE: rtl/sesr_back.sv
// back end: event store, drain sequencer and sample output register
module sesr_back
    import sesr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 512
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    input  logic [AMP_W-1:0]      amplitude,
    input  logic [STEP_W-1:0]     sample_step,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_CHECK = 3'b100
    } state_t;

    spk_evt_t                mem [QUEUE_DEPTH];
    spk_evt_t                rd_data_reg;
    state_t                  state_reg;
    state_t                  state_next;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_next;
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        wr_ptr_next;
    logic [PTR_W-1:0]        rd_inc;
    logic [PTR_W-1:0]        wr_inc;
    logic [PTR_W-1:0]        rd_addr;
    logic [TIME_W-1:0]       pos_reg;
    logic [TIME_W-1:0]       pos_next;
    logic                    lvl_reg;
    logic                    lvl_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic [OUT_DATA_W-1:0]   out_data_next;
    logic                    mem_we;
    logic                    hit;
    logic                    emit;
    logic [SAMPLE_W-1:0]     amp_ext;
    logic [SAMPLE_W-1:0]     sample;

    assign rd_inc   = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign wr_inc   = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign hit      = (rd_ptr_reg != wr_ptr_reg) && (rd_data_reg.stamp <= pos_reg);
    assign amp_ext  = {1'b0, amplitude};
    assign sample   = lvl_reg ? amp_ext : (~amp_ext + SAMPLE_W'(1));
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        pos_next       = pos_reg;
        lvl_next       = lvl_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        emit           = 1'b0;
        rd_addr        = rd_ptr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.is_render)
                    begin
                        state_next = ST_FETCH;
                    end
                    else if (wr_inc != rd_ptr_reg)
                    begin
                        mem_we      = 1'b1;
                        wr_ptr_next = wr_inc;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (hit)
                begin
                    lvl_next    = rd_data_reg.level;
                    rd_ptr_next = rd_inc;
                    rd_addr     = rd_inc;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    emit           = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = {{(OUT_DATA_W - SAMPLE_W - 1){1'b0}}, lvl_reg, sample};
                    pos_next       = pos_reg + {{(TIME_W - STEP_W){1'b0}}, sample_step};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            pos_reg       <= '0;
            lvl_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            pos_reg       <= pos_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= {cmd.level, cmd.stamp};
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_emit_step: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> pos_reg == $past(pos_reg) + {{(TIME_W - STEP_W){1'b0}}, $past(sample_step)})
        else $error("playback position did not advance by the step");

    a_drain_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CHECK) |=> rd_ptr_reg == $past(rd_ptr_reg))
        else $error("read pointer moved outside the drain");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> wr_ptr_reg != rd_ptr_reg)
        else $error("event store overrun");

    a_emit_level: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_tvalid && (m_tdata[SAMPLE_W] == $past(lvl_reg)))
        else $error("rendered item lost its level");

endmodule

FILE: rtl/speaker_event_sample_renderer.sv
// top level of the speaker event sample renderer
//
// items arrive on the s_ channel: s_tuser carries the function (tick, port
// write, render), s_tdata the byte written to the speaker port. a tick bumps
// the 64-bit time counter, a port write whose level differs from the last one
// records a timestamped event, a render drains events due at the playback
// position and emits one item on the m_ channel holding +/- amplitude and the
// level. registers amplitude (0x0) and sample_step (0x4) sit on the apb port.
// a write passes through the command queue into the event store, which drops
// it when full. a render steps the back sequencer through its idle, fetch and
// check states, reading due events one at a time through its single event
// store read port; its item enters the output register once the drain ends
// and that register is free. the front keeps taking items while the 4-entry
// command queue has room.
// reset clears the time counter, pointers, playback position and levels and
// restores amplitude 8000 and step 37; the event store needs no clearing.
// when m_tready is low the result waits in the output register and the back
// waits in its check state, the queue fills, and then s_tready falls.
module speaker_event_sample_renderer
    import sesr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 512
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] port_value
    input  logic [IN_USER_W-1:0]  s_tuser,   // [1:0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] sample, [16] level, [23:17] zero
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    logic [AMP_W-1:0]  amplitude_reg;
    logic [STEP_W-1:0] sample_step_reg;
    logic              cfg_we;
    reg_idx_t          reg_sel;
    logic              cmd_push;
    cmd_t              push_cmd;
    logic              cmdq_full;
    logic              head_valid;
    cmd_t              head_cmd;
    logic              cmd_pop;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_comb
    begin
        case (reg_sel)
            REG_AMPLITUDE:   prdata = {{(PDATA_W - AMP_W){1'b0}}, amplitude_reg};
            REG_SAMPLE_STEP: prdata = {{(PDATA_W - STEP_W){1'b0}}, sample_step_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg   <= AMP_W'(8000);
            sample_step_reg <= STEP_W'(37);
        end
        else if (cfg_we)
        begin
            case (reg_sel)
                REG_AMPLITUDE:   amplitude_reg   <= pwdata[AMP_W-1:0];
                REG_SAMPLE_STEP: sample_step_reg <= pwdata[STEP_W-1:0];
                default:         amplitude_reg   <= amplitude_reg;
            endcase
        end
    end

    sesr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmdq_full (cmdq_full),
        .cmd_push  (cmd_push),
        .cmd_out   (push_cmd)
    );

    sesr_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (push_cmd),
        .full       (cmdq_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (cmd_pop)
    );

    sesr_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (head_valid),
        .cmd         (head_cmd),
        .cmd_pop     (cmd_pop),
        .amplitude   (amplitude_reg),
        .sample_step (sample_step_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

FILE: test/speaker_event_sample_renderer_tb.sv
// testbench for the speaker event sample renderer: directed and random stream traffic checked against a predictor
`timescale 1ns / 100ps

module speaker_event_sample_renderer_tb;
    import sesr_pkg::*;

    localparam int EVT_DEPTH   = 512;
    localparam int SETTLE      = 12;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic              level;
    } toggle_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                level;
    } sample_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_W-1:0]    paddr    = '0;
    logic [PDATA_W-1:0]    pwdata   = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // predicted block state
    logic [TIME_W-1:0]   mirror_time       = '0;
    logic                mirror_writer_lvl = 1'b0;
    logic [TIME_W-1:0]   mirror_pos        = '0;
    logic                mirror_play_lvl   = 1'b0;
    logic [AMP_W-1:0]    mirror_amp        = AMP_W'(8000);
    logic [STEP_W-1:0]   mirror_step       = STEP_W'(37);
    toggle_t             toggle_queue[$];
    sample_t             pending_samples[$];

    int mismatches     = 0;
    int items_in       = 0;
    int samples_out    = 0;
    int drained_events = 0;
    int dropped_events = 0;
    int deepest_drain  = 0;
    int quiet_cycles   = 0;
    int rx_hold        = 0;
    bit steady         = 1'b0;

    speaker_event_sample_renderer #(
        .QUEUE_DEPTH(EVT_DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 100)
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_DATA_W-1:0] toggle_value(input logic lvl);
        logic [1:0] top;
        top = lvl ? 2'($urandom_range(1, 3)) : 2'b00;
        return {top, 6'($urandom_range(0, 63))};
    endfunction

    task automatic mirror_item(input func_t f, input logic [IN_DATA_W-1:0] pv);
        toggle_t ev;
        sample_t res;
        int      drained;
        logic    lvl;
        drained = 0;
        lvl = |pv[7:6];
        case (f)
            FUNC_TICK:
            begin
                mirror_time = mirror_time + TIME_W'(1);
            end
            FUNC_WRITE:
            begin
                if (lvl != mirror_writer_lvl)
                begin
                    mirror_writer_lvl = lvl;
                    if (toggle_queue.size() < EVT_DEPTH - 1)
                    begin
                        ev.stamp = mirror_time;
                        ev.level = lvl;
                        toggle_queue.push_back(ev);
                    end
                    else
                        dropped_events = dropped_events + 1;
                end
            end
            FUNC_RENDER:
            begin
                while (toggle_queue.size() != 0 && toggle_queue[0].stamp <= mirror_pos)
                begin
                    ev = toggle_queue.pop_front();
                    mirror_play_lvl = ev.level;
                    drained = drained + 1;
                end
                drained_events = drained_events + drained;
                if (drained > deepest_drain)
                    deepest_drain = drained;
                res.level  = mirror_play_lvl;
                res.sample = mirror_play_lvl ? SAMPLE_W'(mirror_amp)
                                             : SAMPLE_W'(0) - SAMPLE_W'(mirror_amp);
                pending_samples.push_back(res);
                mirror_pos = mirror_pos + TIME_W'(mirror_step);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] word);
        sample_t want;
        samples_out = samples_out + 1;
        if (pending_samples.size() == 0)
            report_mismatch("unexpected sample", word, 0);
        else
        begin
            want = pending_samples.pop_front();
            if (word[15:0] !== want.sample)
                report_mismatch("sample", word[15:0], want.sample);
            if (word[16] !== want.level)
                report_mismatch("level", word[16], want.level);
            if (word[OUT_DATA_W-1:17] !== '0)
                report_mismatch("padding", word[OUT_DATA_W-1:17], 0);
        end
    endtask

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mirror_item(func_t'(s_tuser), s_tdata);
            items_in = items_in + 1;
        end
        if (m_tvalid && m_tready)
            check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles, %0d samples outstanding",
                         quiet_cycles, pending_samples.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_hold = pick_pause();
        end
    end

    task automatic send_item(input func_t f, input logic [IN_DATA_W-1:0] pv);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= pv;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        gap = pick_pause();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
    endtask

    task automatic reg_read(input reg_idx_t idx, output logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        value = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        logic [PDATA_W-1:0] masked;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_AMPLITUDE)
        begin
            mirror_amp = value[AMP_W-1:0];
            masked = PDATA_W'(mirror_amp);
        end
        else
        begin
            mirror_step = value[STEP_W-1:0];
            masked = PDATA_W'(mirror_step);
        end
        @(negedge clk);
        reg_read(idx, readback);
        if (readback !== masked)
            report_mismatch("register readback", readback, masked);
    endtask

    task automatic set_config(input logic [PDATA_W-1:0] amp, input logic [PDATA_W-1:0] step);
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        reg_write(REG_AMPLITUDE, amp);
        reg_write(REG_SAMPLE_STEP, step);
    endtask

    task automatic test_reset_values();
        logic [PDATA_W-1:0] value;
        reg_read(REG_AMPLITUDE, value);
        if (value !== PDATA_W'(mirror_amp))
            report_mismatch("amplitude after reset", value, mirror_amp);
        reg_read(REG_SAMPLE_STEP, value);
        if (value !== PDATA_W'(mirror_step))
            report_mismatch("sample step after reset", value, mirror_step);
    endtask

    task automatic test_level_changes();
        send_item(FUNC_RENDER, 8'h00);
        send_item(FUNC_WRITE,  8'hFF);
        send_item(FUNC_WRITE,  8'hC0);
        send_item(FUNC_WRITE,  8'h80);
        send_item(FUNC_WRITE,  8'h40);
        send_item(FUNC_RENDER, 8'h00);
        send_item(FUNC_WRITE,  8'h3F);
        send_item(FUNC_WRITE,  8'h00);
        send_item(FUNC_TICK,   8'hFF);
        send_item(FUNC_TICK,   8'h00);
        send_item(FUNC_WRITE,  8'h55);
        wait_drained();
        send_item(FUNC_RENDER, 8'hAA);
        send_item(FUNC_UNUSED, 8'hFF);
        send_item(FUNC_UNUSED, 8'h00);
        send_item(FUNC_WRITE,  8'h2A);
        send_item(FUNC_RENDER, 8'hFF);
        send_item(FUNC_RENDER, 8'h00);
    endtask

    // fill the event queue past its capacity, then drain it in one render
    task automatic test_queue_overflow();
        int i;
        for (i = 0; i < EVT_DEPTH + 10; i++)
            send_item(FUNC_WRITE, toggle_value(!mirror_writer_lvl));
        send_item(FUNC_RENDER, 8'($urandom));
        send_item(FUNC_WRITE, toggle_value(!mirror_writer_lvl));
        send_item(FUNC_RENDER, 8'($urandom));
    endtask

    task automatic test_random_traffic(input logic [PDATA_W-1:0] amp,
                                       input logic [PDATA_W-1:0] step, input int count);
        int                   n;
        int                   r;
        func_t                f;
        logic [IN_DATA_W-1:0] pv;
        set_config(amp, step);
        for (n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 149) == 0)
                wait_drained();
            r  = $urandom_range(0, 99);
            pv = 8'($urandom);
            if (r < 55)
                f = FUNC_TICK;
            else if (r < 80)
            begin
                f = FUNC_WRITE;
                if ($urandom_range(0, 3) != 0)
                    pv = toggle_value(!mirror_writer_lvl);
            end
            else if (r < 95)
                f = FUNC_RENDER;
            else
                f = FUNC_UNUSED;
            send_item(f, pv);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_values();
        test_level_changes();
        test_queue_overflow();
        test_random_traffic(32'd32767, 32'd5, 150);
        test_random_traffic(32'd0, 32'd1, 130);
        test_random_traffic(32'd1, 32'd0, 120);
        test_random_traffic(32'hFFFF_FFFF, 32'hFFFF_FFFF, 120);
        test_random_traffic($urandom, $urandom_range(2, 12), 180);
        test_random_traffic($urandom_range(0, 32767), $urandom_range(1, 65535), 100);
        test_random_traffic(32'd8000, 32'd37, 100);
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        $display("run covered %0d items in and %0d samples out", items_in, samples_out);
        $display("speaker events: %0d drained (up to %0d in one render), %0d dropped when full",
                 drained_events, deepest_drain, dropped_events);
        if (mismatches == 0 && pending_samples.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sesr_pkg.sv
rtl/sesr_front.sv
rtl/sesr_cmdq.sv
rtl/sesr_back.sv
rtl/speaker_event_sample_renderer.sv
test/speaker_event_sample_renderer_tb.sv
